FILE: design/assert_macros.svh
// assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define WFHA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that is also evaluated during reset
`define WFHA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/wfha_pkg.sv
package wfha_pkg;

  // width of the hole count register
  localparam int COUNT_WIDTH = 5;
  localparam logic [COUNT_WIDTH-1:0] RESET_HOLE_COUNT = 5'd16;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  hole_index;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  hole_id;
    logic [15:0] remaining;
  } out_item_t;

endpackage

FILE: design/wfha_mem.sv
module wfha_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;

  // per-entry valid bits, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

FILE: design/wfha_ctrl.sv
module wfha_ctrl #(
  parameter int MAX_HOLES  = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [$clog2(MAX_HOLES+1)-1:0] n_active,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  wfha_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output wfha_pkg::out_item_t          out_data,
  output logic                         wr_en,
  output logic [$clog2(MAX_HOLES)-1:0] wr_addr,
  output logic [SIZE_WIDTH-1:0]        wr_data,
  output logic                         rd_en,
  output logic [$clog2(MAX_HOLES)-1:0] rd_addr,
  input  logic [SIZE_WIDTH-1:0]        rd_data
);

  import wfha_pkg::*;

  localparam int AW = $clog2(MAX_HOLES);
  localparam int CW = $clog2(MAX_HOLES + 1);

  state_t            state;
  state_t            state_next;
  in_item_t          item;
  logic [CW-1:0]     rd_ptr;
  logic              pipe_valid;
  logic [AW-1:0]     pipe_idx;
  logic              found;
  logic [AW-1:0]     best_idx;
  logic [SIZE_WIDTH-1:0] best_val;
  logic              out_load;
  out_item_t         out_next;
  logic              slot_free;
  logic              idx_in_range;
  logic              fits;
  logic [SIZE_WIDTH-1:0] amt;
  logic [SIZE_WIDTH-1:0] left;

  assign slot_free    = !out_valid || !out_stall;
  assign amt          = SIZE_WIDTH'(item.amount);
  assign left         = best_val - amt;
  assign idx_in_range = 9'(item.hole_index) < 9'(MAX_HOLES);
  assign fits         = found && (amt <= best_val);
  assign in_stall     = (state != ST_IDLE);
  assign rd_addr      = rd_ptr[AW-1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory strobes and result
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = best_idx;
    wr_data    = left;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    out_next   = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.cmd == CMD_ALLOC) ? ST_SCAN : ST_LOAD;
        end
      end
      ST_LOAD: begin
        wr_addr = AW'(item.hole_index);
        wr_data = amt;
        out_next.hole_id = item.hole_index;
        out_next.remaining = idx_in_range ? 16'(amt) : 16'd0;
        if (slot_free) begin
          wr_en      = idx_in_range;
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        rd_en = (rd_ptr < n_active);
        if ((rd_ptr == n_active) && !pipe_valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fits) begin
          out_next.granted   = 1'b1;
          out_next.hole_id   = 4'(best_idx);
          out_next.remaining = 16'(left);
        end
        if (slot_free) begin
          wr_en      = fits;
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // captured item
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_valid) begin
      item <= in_data;
    end
  end

  // scan pointer and read pipeline tag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr     <= '0;
      pipe_valid <= 1'b0;
    end else begin
      if (state == ST_IDLE) begin
        rd_ptr <= '0;
      end else if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      pipe_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx <= rd_addr;
  end

  // running maximum, strict compare keeps the lowest id on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (state == ST_IDLE) begin
      found <= 1'b0;
    end else if (pipe_valid && (!found || (rd_data > best_val))) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_valid && (!found || (rd_data > best_val))) begin
      best_idx <= pipe_idx;
      best_val <= rd_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

endmodule

FILE: design/worst_fit_hole_allocator_unit.sv
// Worst-fit allocator over a table of free holes.
// Input channel (in_valid / in_stall / in_data) carries one beat per command:
// a load writes a hole's free size, an allocate asks for a block of amount.
// Output channel (out_valid / out_stall / out_data) returns exactly one beat
// per input beat, in order: the grant flag, the hole id and the size left.
// The hole count register is written through cfg_write / cfg_data; the user
// must write it only while idle, as the block does not enforce it. A load
// writes the hole and loads its result from the load state. An allocate reads
// holes 0 to n-1 through the single read port of the hole store, one a cycle,
// n being the hole count capped at MAX_HOLES, then loads its result from the
// finish state. One command is in flight at a time; the next beat is taken
// only once the unit is back in idle after the result has been loaded.
// Reset clears every hole to zero through per-entry valid bits and sets the
// hole count to 16; no clearing pass is needed.
// A stalled result is held in the output register; the command that made it
// is finished and a new input beat may be taken while it waits.
`include "assert_macros.svh"

module worst_fit_hole_allocator_unit #(
  parameter int MAX_HOLES  = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [4:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  wfha_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wfha_pkg::out_item_t out_data
);

  import wfha_pkg::*;

  localparam int AW = $clog2(MAX_HOLES);
  localparam int CW = $clog2(MAX_HOLES + 1);

  logic [COUNT_WIDTH-1:0] hole_count;
  logic [CW-1:0]          n_active;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [SIZE_WIDTH-1:0]  wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [SIZE_WIDTH-1:0]  rd_data;

  // hole count register
  always_ff @(posedge clk) begin
    if (rst) begin
      hole_count <= RESET_HOLE_COUNT;
    end else if (cfg_write) begin
      hole_count <= cfg_data;
    end
  end

  // holes taking part, capped at the table size
  assign n_active = (9'(hole_count) > 9'(MAX_HOLES)) ? CW'(MAX_HOLES) : CW'(hole_count);

  wfha_ctrl #(
    .MAX_HOLES  (MAX_HOLES),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .n_active  (n_active),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  wfha_mem #(
    .DEPTH (MAX_HOLES),
    .WIDTH (SIZE_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // checks
  `WFHA_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "accepted beat did not make the unit busy")
  `WFHA_ASSERT(a_result_from_busy, ($rose(out_valid) && !$past(rst)) |-> $past(in_stall), "result appeared with no command in flight")
  `WFHA_ASSERT(a_done_has_result, ($fell(in_stall) && !$past(rst)) |-> out_valid, "command finished without a result beat")

endmodule

FILE: bench/testbench.sv
module testbench;
  import wfha_pkg::*;

  localparam int HOLES = 16;
  localparam int CLK_HALF = 6;

  logic      clk;
  logic      rst = 1'b1;
  logic      cfg_write = 1'b0;
  logic [4:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // commands waiting to be driven, grants waiting to come back
  in_item_t  pending_commands[$];
  out_item_t expected_grants[$];

  // local copy of the hole table and the count register
  logic [15:0] free_size [HOLES];
  logic [4:0]  alloc_holes;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;

  worst_fit_hole_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // apply one command to the hole table and return the beat it should produce
  function automatic out_item_t worst_fit_step(in_item_t item);
    out_item_t   res;
    int unsigned n;
    int unsigned best;
    bit          found;
    res = '0;
    if (item.cmd == CMD_LOAD) begin
      free_size[item.hole_index] = item.amount;
      res.hole_id = item.hole_index;
      res.remaining = item.amount;
      return res;
    end
    n = (alloc_holes > HOLES) ? HOLES : alloc_holes;
    best = 0;
    found = 1'b0;
    // strict compare keeps the lowest id on a tie
    for (int unsigned i = 0; i < n; i++) begin
      if (!found || free_size[i] > free_size[best]) begin
        best = i;
        found = 1'b1;
      end
    end
    if (found && item.amount <= free_size[best]) begin
      free_size[best] = free_size[best] - item.amount;
      res.granted = 1'b1;
      res.hole_id = best[3:0];
      res.remaining = free_size[best];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic queue_command(cmd_t cmd, logic [3:0] idx, logic [15:0] amt);
    in_item_t item;
    item.cmd = cmd;
    item.hole_index = idx;
    item.amount = amt;
    pending_commands.push_back(item);
  endtask

  // a random size biased towards small values so that ties and exact fits occur
  function automatic logic [15:0] pick_size();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(15));
      5, 6:    return 16'($urandom_range(255));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic queue_random(int count);
    cmd_t cmd;
    for (int k = 0; k < count; k++) begin
      cmd = ($urandom_range(99) < 40) ? CMD_LOAD : CMD_ALLOC;
      queue_command(cmd, 4'($urandom_range(15)), pick_size());
    end
  endtask

  // hold until every queued beat is sent and every grant has come back
  task automatic wait_for_drain();
    @(negedge clk);
    while (pending_commands.size() != 0 || in_valid || expected_grants.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_hole_count(logic [4:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    alloc_holes = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // input driver: predicts each beat as it is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_grants.push_back(worst_fit_step(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_commands.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: random back-pressure and field checks
  always @(posedge clk) begin : grant_check
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected beat, hole_id", out_data.hole_id, -1);
        end else begin
          want = expected_grants.pop_front();
          if (out_data.granted !== want.granted)
            report_mismatch("granted", out_data.granted, want.granted);
          if (out_data.hole_id !== want.hole_id)
            report_mismatch("hole_id", out_data.hole_id, want.hole_id);
          if (out_data.remaining !== want.remaining)
            report_mismatch("remaining", out_data.remaining, want.remaining);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // stimulus sequence
  initial begin
    logic [4:0] count_plan [9];
    count_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd8, 5'd15, 5'd16};
    foreach (free_size[i]) free_size[i] = '0;
    alloc_holes = RESET_HOLE_COUNT;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: zero request on an empty table, failures, ties, exact fit, extremes
    send_idle_pct = 36;
    recv_idle_pct = 58;
    queue_command(CMD_ALLOC, 4'd5, 16'd0);
    queue_command(CMD_ALLOC, 4'd0, 16'd1);
    queue_command(CMD_LOAD, 4'd15, 16'hFFFF);
    queue_command(CMD_LOAD, 4'd0, 16'd0);
    queue_command(CMD_LOAD, 4'd3, 16'd100);
    queue_command(CMD_LOAD, 4'd7, 16'd100);
    queue_command(CMD_ALLOC, 4'd15, 16'hFFFF);
    queue_command(CMD_ALLOC, 4'd0, 16'd1);
    queue_command(CMD_ALLOC, 4'd0, 16'd100);
    queue_command(CMD_ALLOC, 4'd0, 16'd100);
    queue_command(CMD_ALLOC, 4'd0, 16'd0);
    queue_command(CMD_LOAD, 4'd10, 16'h8000);
    queue_command(CMD_LOAD, 4'd5, 16'h7FFF);
    queue_command(CMD_ALLOC, 4'd9, 16'h7FFF);
    queue_command(CMD_ALLOC, 4'd9, 16'h7FFF);
    queue_command(CMD_ALLOC, 4'd0, 16'hFFFF);
    queue_command(CMD_LOAD, 4'd15, 16'h5555);
    queue_command(CMD_LOAD, 4'd1, 16'hAAAA);
    queue_command(CMD_ALLOC, 4'd0, 16'h0AAA);
    wait_for_drain();

    // random segments: three idling modes, each over a sweep of hole counts
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 58 : 0;
      recv_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 36 : 0;
      for (int seg = 0; seg < 9; seg++) begin
        write_hole_count((seg == 8) ? 5'($urandom_range(31)) : count_plan[seg]);
        queue_random(50);
        wait_for_drain();
      end
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // run time limit
  initial begin
    #(2 * CLK_HALF * 800000);
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/wfha_pkg.sv
design/wfha_mem.sv
design/wfha_ctrl.sv
design/worst_fit_hole_allocator_unit.sv
bench/testbench.sv
